// ----- hw/rtl/jsu_pkg.sv -----
// types, codes and helpers shared by the json string unescape block
package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in_word;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic [1:0] outcome;
    } t_out_word;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    // scan state carried between bytes; only three hex digits are ever held
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_count;
        logic [11:0] hex_value;
        logic        discarding;
    } t_scan_state;

    localparam logic [1:0] OUT_CONTINUE = 2'd0;
    localparam logic [1:0] OUT_CLOSED   = 2'd1;
    localparam logic [1:0] OUT_ERROR    = 2'd2;
    localparam logic [1:0] OUT_UNCLOSED = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_FF  = 8'h0c;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic [1:0] HEX_LAST = 2'd3;

    // nibble value in [3:0], bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b0, 4'(c - 8'h37)};
        end
        return d;
    endfunction

endpackage

// ----- hw/rtl/jsu_decode.sv -----
// next-state and result logic for one raw string byte
module jsu_decode (
    input  jsu_pkg::t_scan_state i_state,
    input  jsu_pkg::t_in_word    i_word,
    output jsu_pkg::t_scan_state o_state,
    output jsu_pkg::t_out_word   o_result,
    output logic                 o_has_result
);

    logic [7:0]  c;
    logic        emit;
    logic [7:0]  ch;
    logic [1:0]  outcome;
    logic        normal;
    logic [4:0]  d;
    logic [15:0] full_value;
    jsu_pkg::t_scan_state st;

    always_comb begin
        c          = i_word.in_byte;
        emit       = 1'b0;
        ch         = 8'h00;
        outcome    = jsu_pkg::OUT_CONTINUE;
        normal     = 1'b0;
        st         = i_state;
        d          = jsu_pkg::hex_digit(c);
        full_value = {i_state.hex_value, d[3:0]};

        unique case (i_state.mode)
            jsu_pkg::MODE_ESCAPE: begin
                st.mode = jsu_pkg::MODE_NORMAL;
                unique case (c)
                    jsu_pkg::CH_QUOTE: begin emit = 1'b1; ch = jsu_pkg::CH_QUOTE; end
                    jsu_pkg::CH_BSL:   begin emit = 1'b1; ch = jsu_pkg::CH_BSL;   end
                    jsu_pkg::CH_SLASH: begin emit = 1'b1; ch = jsu_pkg::CH_SLASH; end
                    jsu_pkg::CH_B:     begin emit = 1'b1; ch = jsu_pkg::CH_BS;    end
                    jsu_pkg::CH_F:     begin emit = 1'b1; ch = jsu_pkg::CH_FF;    end
                    jsu_pkg::CH_N:     begin emit = 1'b1; ch = jsu_pkg::CH_LF;    end
                    jsu_pkg::CH_R:     begin emit = 1'b1; ch = jsu_pkg::CH_CR;    end
                    jsu_pkg::CH_T:     begin emit = 1'b1; ch = jsu_pkg::CH_TAB;   end
                    jsu_pkg::CH_U: begin
                        st.mode      = jsu_pkg::MODE_HEX;
                        st.hex_count = 2'd0;
                        st.hex_value = 12'h000;
                    end
                    // unknown escape: backslash dropped, byte handled as plain
                    default: normal = 1'b1;
                endcase
            end
            jsu_pkg::MODE_HEX: begin
                if (d[4]) begin
                    outcome = jsu_pkg::OUT_ERROR;
                end else if (i_state.hex_count == jsu_pkg::HEX_LAST) begin
                    st.mode      = jsu_pkg::MODE_NORMAL;
                    st.hex_count = 2'd0;
                    st.hex_value = 12'h000;
                    if (full_value[15:8] != 8'h00) begin
                        outcome = jsu_pkg::OUT_ERROR;
                    end else begin
                        emit = 1'b1;
                        ch   = full_value[7:0];
                    end
                end else begin
                    st.hex_value = full_value[11:0];
                    st.hex_count = i_state.hex_count + 2'd1;
                end
            end
            default: normal = 1'b1;
        endcase

        if (normal) begin
            st.mode = jsu_pkg::MODE_NORMAL;
            priority if (c == jsu_pkg::CH_BSL) begin
                st.mode = jsu_pkg::MODE_ESCAPE;
            end else if (c == jsu_pkg::CH_QUOTE) begin
                outcome = jsu_pkg::OUT_CLOSED;
            end else if (c == jsu_pkg::CH_NUL) begin
                st.discarding = 1'b1;
            end else begin
                emit = 1'b1;
                ch   = c;
            end
        end

        if (st.discarding) begin
            emit = 1'b0;
        end

        if (outcome == jsu_pkg::OUT_CONTINUE && i_word.text_end) begin
            if (st.mode == jsu_pkg::MODE_ESCAPE || st.mode == jsu_pkg::MODE_HEX) begin
                outcome = jsu_pkg::OUT_ERROR;
            end else begin
                outcome = jsu_pkg::OUT_UNCLOSED;
            end
        end

        // any final outcome returns to idle
        if (outcome != jsu_pkg::OUT_CONTINUE) begin
            st.mode       = jsu_pkg::MODE_NORMAL;
            st.hex_count  = 2'd0;
            st.hex_value  = 12'h000;
            st.discarding = 1'b0;
        end

        o_state             = st;
        o_result.char_valid = emit;
        o_result.char_out   = emit ? ch : 8'h00;
        o_result.outcome    = outcome;
        o_has_result        = emit || (outcome != jsu_pkg::OUT_CONTINUE);
    end

endmodule

// ----- hw/rtl/json_string_unescape.sv -----
// json string body unescaper: top level with scan state, result register and skid
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_word  (jsu_pkg::t_in_word)
//  out     | output    | o_out_valid/ i_out_stall| o_out_word (jsu_pkg::t_out_word)
//
// one byte per cycle while o_in_stall is low; the scan state updates in the cycle the byte is taken
// and its result is registered in the output register, or in the skid register when stalled
// a skid register catches the result that arrives while the output is stalled;
// o_in_stall is high only while that skid register is full
// bytes that give no result are dropped from the output stream
// synchronous active-low reset clears the scan state and the valid flags of both result registers
module json_string_unescape (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  jsu_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jsu_pkg::t_out_word  o_out_word
);

    jsu_pkg::t_scan_state r_state;
    jsu_pkg::t_scan_state n_state;
    jsu_pkg::t_out_word   step_result;
    logic                 step_has_result;

    logic                 r_out_valid;
    jsu_pkg::t_out_word   r_out_word;
    logic                 r_skid_valid;
    jsu_pkg::t_out_word   r_skid_word;

    logic                 in_accept;
    logic                 res_valid;
    logic                 out_take;

    jsu_decode u_decode (
        .i_state      (r_state),
        .i_word       (i_in_word),
        .o_state      (n_state),
        .o_result     (step_result),
        .o_has_result (step_has_result)
    );

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign res_valid  = in_accept && step_has_result;
    assign out_take   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= jsu_pkg::MODE_NORMAL;
            r_state.hex_count  <= 2'd0;
            r_state.hex_value  <= 12'h000;
            r_state.discarding <= 1'b0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (res_valid) begin
                r_out_word <= step_result;
            end
        end else if (res_valid) begin
            r_skid_word <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // skid only ever holds a word behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // a result meeting a stalled, full output register fills the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid && res_valid && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("stalled result not caught by skid register");

    // a final outcome leaves the scanner idle
    a_idle_after_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && step_result.outcome != jsu_pkg::OUT_CONTINUE) |=>
        (r_state.mode == jsu_pkg::MODE_NORMAL && !r_state.discarding
         && r_state.hex_count == 2'd0))
        else $error("scan state not cleared after final outcome");

endmodule

// ----- test/json_string_unescape_checker.sv -----
// checker for the json string unescaper: predicts decoded words and compares them
module json_string_unescape_checker
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // predicted scan state
    t_mode       scan_md;
    logic [1:0]  digits_seen;
    logic [15:0] code_acc;
    logic        dropping;

    t_out_word   decoded_q[$];

    function automatic void clear_scan();
        scan_md     = MODE_NORMAL;
        digits_seen = 2'd0;
        code_acc    = 16'd0;
        dropping    = 1'b0;
    endfunction

    // advances the predicted state by one byte; returns 1 when a word comes out
    function automatic bit unescape_byte(input t_in_word w, output t_out_word res);
        logic [7:0] c;
        logic [7:0] ch;
        logic [1:0] oc;
        logic       emit;
        logic       as_plain;
        int         nib;
        c        = w.in_byte;
        ch       = 8'h00;
        oc       = OUT_CONTINUE;
        emit     = 1'b0;
        as_plain = 1'b0;
        nib      = -1;
        case (scan_md)
            MODE_ESCAPE: begin
                scan_md = MODE_NORMAL;
                case (c)
                    CH_QUOTE, CH_BSL, CH_SLASH: begin
                        emit = 1'b1;
                        ch   = c;
                    end
                    CH_B: begin emit = 1'b1; ch = CH_BS;  end
                    CH_F: begin emit = 1'b1; ch = CH_FF;  end
                    CH_N: begin emit = 1'b1; ch = CH_LF;  end
                    CH_R: begin emit = 1'b1; ch = CH_CR;  end
                    CH_T: begin emit = 1'b1; ch = CH_TAB; end
                    CH_U: begin
                        scan_md     = MODE_HEX;
                        digits_seen = 2'd0;
                        code_acc    = 16'd0;
                    end
                    // unknown escape: backslash vanishes, byte is read as plain
                    default: as_plain = 1'b1;
                endcase
            end
            MODE_HEX: begin
                if (c >= "0" && c <= "9") nib = int'(c) - int'("0");
                else if (c >= "a" && c <= "f") nib = int'(c) - int'("a") + 10;
                else if (c >= "A" && c <= "F") nib = int'(c) - int'("A") + 10;
                if (nib < 0) begin
                    oc = OUT_ERROR;
                end else begin
                    code_acc = {code_acc[11:0], 4'(nib)};
                    if (digits_seen == HEX_LAST) begin
                        scan_md     = MODE_NORMAL;
                        digits_seen = 2'd0;
                        if (code_acc > 16'd255) begin
                            oc = OUT_ERROR;
                        end else begin
                            emit = 1'b1;
                            ch   = code_acc[7:0];
                        end
                        code_acc = 16'd0;
                    end else begin
                        digits_seen = digits_seen + 2'd1;
                    end
                end
            end
            default: as_plain = 1'b1;
        endcase

        if (as_plain) begin
            scan_md = MODE_NORMAL;
            if (c == CH_BSL) begin
                scan_md = MODE_ESCAPE;
            end else if (c == CH_QUOTE) begin
                oc = OUT_CLOSED;
            end else if (c == CH_NUL) begin
                dropping = 1'b1;
            end else begin
                emit = 1'b1;
                ch   = c;
            end
        end

        if (dropping) emit = 1'b0;

        // a closing quote on the last byte still counts as closed
        if (oc == OUT_CONTINUE && w.text_end) begin
            oc = (scan_md == MODE_ESCAPE || scan_md == MODE_HEX) ? OUT_ERROR : OUT_UNCLOSED;
        end

        if (oc != OUT_CONTINUE) clear_scan();

        res.char_valid = emit;
        res.char_out   = emit ? ch : 8'h00;
        res.outcome    = oc;
        return emit || oc != OUT_CONTINUE;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            clear_scan();
            decoded_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (decoded_q.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $display("unexpected word: valid=%0b char=%02h outcome=%0d",
                                 got.char_valid, got.char_out, got.outcome);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.char_valid !== want.char_valid || got.char_out !== want.char_out ||
                        got.outcome !== want.outcome) begin
                        if (o_fail_count < MAX_REPORTS) begin
                            $display("mismatch: expected valid=%0b char=%02h outcome=%0d, %s",
                                     want.char_valid, want.char_out, want.outcome,
                                     $sformatf("got valid=%0b char=%02h outcome=%0d",
                                               got.char_valid, got.char_out, got.outcome));
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (unescape_byte(i_in_word, want)) decoded_q = {decoded_q, want};
            end
        end
        o_words_due = decoded_q.size();
    end

endmodule

// ----- test/json_string_unescape_test.sv -----
// testbench top for the json string unescaper: stimulus, stall patterns and verdict
module json_string_unescape_test;
    import jsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    int fail_count;
    int words_due;
    int bytes_sent    = 0;
    int send_idle_pct = 8;
    int rcv_idle_pct  = 68;
    int hold_asked    = 0;

    always #5 clk = ~clk;

    json_string_unescape u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    json_string_unescape_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic ends);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        in_word.in_byte  <= b;
        in_word.text_end <= ends;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'("0") + 8'(v);
        return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
    endfunction

    task automatic send_unicode(input logic [15:0] v, input logic ends);
        send_byte(CH_BSL, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte(hex_char(v[15:12]), 1'b0);
        send_byte(hex_char(v[11:8]), 1'b0);
        send_byte(hex_char(v[7:4]), 1'b0);
        send_byte(hex_char(v[3:0]), ends);
    endtask

    // one string body built from random tokens, mostly well formed
    task automatic send_body();
        int         n_tok;
        int         kind;
        int         steps;
        logic [7:0] b;
        n_tok = $urandom_range(1, 12);
        for (int t = 0; t < n_tok; t++) begin
            kind = $urandom_range(99);
            if (kind < 48) begin
                send_byte(plain_byte(), 1'b0);
            end else if (kind < 68) begin
                case ($urandom_range(7))
                    0: b = CH_QUOTE;
                    1: b = CH_BSL;
                    2: b = CH_SLASH;
                    3: b = CH_B;
                    4: b = CH_F;
                    5: b = CH_N;
                    6: b = CH_R;
                    default: b = CH_T;
                endcase
                send_byte(CH_BSL, 1'b0);
                send_byte(b, 1'b0);
            end else if (kind < 80) begin
                send_unicode({8'h00, 8'($urandom_range(255))}, 1'b0);
            end else if (kind < 85) begin
                send_unicode(16'($urandom), 1'b0);
            end else if (kind < 88) begin
                // bad hex digit ends the body with an error
                steps = $urandom_range(3);
                send_byte(CH_BSL, 1'b0);
                send_byte(CH_U, 1'b0);
                for (int k = 0; k < steps; k++)
                    send_byte(hex_char(4'($urandom_range(15))), 1'b0);
                do b = 8'($urandom_range(255));
                while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
                send_byte(b, 1'b0);
                return;
            end else if (kind < 91) begin
                send_byte(CH_NUL, 1'b0);
            end else if (kind < 95) begin
                send_byte(CH_BSL, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b0);
            end else begin
                send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
        kind = $urandom_range(99);
        if (kind < 62) begin
            send_byte(CH_QUOTE, 1'b0);
        end else if (kind < 72) begin
            send_byte(CH_QUOTE, 1'b1);
        end else if (kind < 80) begin
            send_byte(plain_byte(), 1'b1);
        end else if (kind < 86) begin
            send_unicode({8'h00, 8'($urandom_range(255))}, 1'b1);
        end else if (kind < 95) begin
            // text ends inside an escape
            steps = $urandom_range(4);
            send_byte(CH_BSL, steps == 0);
            if (steps > 0) send_byte(CH_U, steps == 1);
            for (int k = 2; k <= steps; k++)
                send_byte(hex_char(4'($urandom_range(15))), k == steps);
        end
    endtask

    task automatic send_random_until(input int target);
        int n;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
            end else begin
                send_body();
            end
        end
    endtask

    task automatic wait_all_decoded();
        while (words_due != 0) @(negedge clk);
    endtask

    // receiver side: random stall, or one long hold when asked
    initial begin
        int hold_seen;
        hold_seen = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // extremes, escaped quote, \u00ff on the last byte leaves the text unclosed
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(CH_BSL, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_unicode(16'h00ff, 1'b1);
        // code above 255
        send_unicode(16'h0100, 1'b0);
        // unknown escape, escaped nul starts discarding, quote on the last byte
        send_byte(CH_BSL, 1'b0);
        send_byte("q", 1'b0);
        send_byte(CH_BSL, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte("A", 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        // bad hex digit, end on a backslash, end on a plain byte
        send_byte(CH_BSL, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte("g", 1'b0);
        send_byte(CH_BSL, 1'b1);
        send_byte(8'h7f, 1'b1);

        send_random_until(400);
        in_valid <= 1'b0;
        wait_all_decoded();

        send_idle_pct = 68;
        rcv_idle_pct  = 8;
        send_random_until(780);
        in_valid <= 1'b0;
        wait_all_decoded();

        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        // long receiver hold while plain bytes keep coming, so the input backs up
        hold_asked <= hold_asked + 1;
        repeat (24) send_byte(plain_byte(), 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_random_until(1150);
        in_valid <= 1'b0;

        wait_all_decoded();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
